// File: rtl/adsr_pkg.sv
// shared types and constants for the adsr envelope gain block
// no dependencies
package adsr_pkg;

  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned GAIN_W   = FRAC_W + 1;
  localparam int unsigned STEP_W   = $clog2(FRAC_W + 1);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << FRAC_W;

  localparam logic [COUNT_W-1:0] ATTACK_RST  = COUNT_W'(4800);
  localparam logic [COUNT_W-1:0] DECAY_RST   = COUNT_W'(4800);
  localparam logic [COUNT_W-1:0] RELEASE_RST = COUNT_W'(4800);
  localparam logic [GAIN_W-1:0]  SUSTAIN_RST = GAIN_W'(32768);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       gate;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [2:0]                 phase;
  } out_t;

endpackage

// File: rtl/adsr_frac_div.sv
// restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_W / den)
// expects num < den; depends on adsr_pkg
module adsr_frac_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [adsr_pkg::COUNT_W-1:0] num_i,
  input  logic [adsr_pkg::COUNT_W-1:0] den_i,
  output logic                         done_o,
  output logic [adsr_pkg::FRAC_W-1:0]  quo_o
);

  logic [adsr_pkg::COUNT_W-1:0] rem_q, den_q;
  logic [adsr_pkg::FRAC_W-1:0]  quo_q;
  logic [adsr_pkg::STEP_W-1:0]  step_q;
  logic                         busy_q, done_q;
  logic [adsr_pkg::COUNT_W:0]   shifted;
  logic                         fits;

  // remainder stays below den, so the doubled value fits one extra bit
  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= adsr_pkg::STEP_W'(adsr_pkg::FRAC_W);
      end else if (busy_q) begin
        step_q <= step_q - adsr_pkg::STEP_W'(1);
        if (step_q == adsr_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? adsr_pkg::COUNT_W'(shifted - {1'b0, den_q})
                    : shifted[adsr_pkg::COUNT_W-1:0];
      quo_q <= {quo_q[adsr_pkg::FRAC_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/adsr_scale_mul.sv
// shared registered multiplier: (a * b) >> FRAC_W, product held in an output register
// depends on adsr_pkg
module adsr_scale_mul (
  input  logic                          clk_i,
  input  logic [adsr_pkg::SAMPLE_W-1:0] a_i,
  input  logic [adsr_pkg::GAIN_W-1:0]   b_i,
  output logic [adsr_pkg::SAMPLE_W-1:0] p_o
);

  logic [adsr_pkg::SAMPLE_W+adsr_pkg::GAIN_W-1:0] prod;
  logic [adsr_pkg::SAMPLE_W-1:0]                  p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[adsr_pkg::FRAC_W +: adsr_pkg::SAMPLE_W];
  end

  assign p_o = p_q;

endmodule

// File: rtl/adsr_envelope_gain_core.sv
// adsr envelope gain: each sample is scaled by an attack/decay/sustain/release gain
// attack, decay and release run the bit-serial divider, then the shared multiplier (release
// uses it twice: release gain, then sample scale); idle and sustain go straight to it
// one item at a time: no new transfer is taken until the result is loaded into the output
// register, which waits while a finished result there has not yet been taken
// reset: phase idle, count zero, config registers at their defaults; depends on adsr_pkg
module adsr_envelope_gain_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  adsr_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output adsr_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adsr_pkg::COUNT_W-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RMUL,
    ST_RGAIN,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MD_ZERO,
    MD_SUS,
    MD_ATTACK,
    MD_DECAY,
    MD_RELEASE
  } mode_e;

  state_e                        state_q;
  mode_e                         mode_q, mode_d;
  adsr_pkg::phase_e              phase_q, res_ph, nxt_ph;
  logic [adsr_pkg::COUNT_W-1:0]  count_q, res_cnt, nxt_cnt;
  logic [adsr_pkg::COUNT_W-1:0]  attack_q, decay_q, release_q, den_d;
  logic [adsr_pkg::GAIN_W-1:0]   sustain_q, sus, gain_q, dec_gain;
  logic [adsr_pkg::SAMPLE_W-1:0] mag_d, mag_q, mul_a, mul_p;
  logic [adsr_pkg::GAIN_W-1:0]   mul_b;
  logic                          neg_q, accept, need_div, div_done, out_valid_q;
  logic [adsr_pkg::FRAC_W-1:0]   quo;
  adsr_pkg::out_t                out_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign sus        = (sustain_q > adsr_pkg::UNITY) ? adsr_pkg::UNITY : sustain_q;

  // resolve phase ends first: attack may hand over to decay, decay to sustain
  always_comb begin
    res_ph  = phase_q;
    res_cnt = count_q;
    if (res_ph == adsr_pkg::PH_ATTACK && res_cnt >= attack_q) begin
      res_ph  = adsr_pkg::PH_DECAY;
      res_cnt = '0;
    end
    if (res_ph == adsr_pkg::PH_DECAY && res_cnt >= decay_q) begin
      res_ph  = adsr_pkg::PH_SUSTAIN;
      res_cnt = '0;
    end
    nxt_ph  = res_ph;
    nxt_cnt = res_cnt;
    mode_d  = MD_ZERO;
    den_d   = attack_q;
    case (res_ph)
      adsr_pkg::PH_ATTACK: begin
        mode_d  = MD_ATTACK;
        nxt_cnt = res_cnt + adsr_pkg::COUNT_W'(1);
      end
      adsr_pkg::PH_DECAY: begin
        mode_d  = MD_DECAY;
        den_d   = decay_q;
        nxt_cnt = res_cnt + adsr_pkg::COUNT_W'(1);
      end
      adsr_pkg::PH_SUSTAIN: begin
        mode_d = MD_SUS;
        if (!in_data_i.gate) begin
          nxt_ph  = adsr_pkg::PH_RELEASE;
          nxt_cnt = '0;
        end
      end
      adsr_pkg::PH_RELEASE: begin
        if (res_cnt >= release_q) begin
          nxt_ph  = adsr_pkg::PH_IDLE;
          nxt_cnt = '0;
        end else begin
          mode_d  = MD_RELEASE;
          den_d   = release_q;
          nxt_cnt = res_cnt + adsr_pkg::COUNT_W'(1);
        end
      end
      default: begin
        nxt_ph = adsr_pkg::PH_IDLE;
        if (in_data_i.gate) begin
          nxt_ph  = adsr_pkg::PH_ATTACK;
          nxt_cnt = '0;
        end
      end
    endcase
  end

  assign need_div = (mode_d == MD_ATTACK) || (mode_d == MD_DECAY) || (mode_d == MD_RELEASE);
  // magnitude of the most negative sample is 2^(SAMPLE_W-1), which still fits unsigned
  assign mag_d    = in_data_i.sample_in[adsr_pkg::SAMPLE_W-1] ?
                    adsr_pkg::SAMPLE_W'(-in_data_i.sample_in) : in_data_i.sample_in;
  assign dec_gain = adsr_pkg::UNITY - adsr_pkg::GAIN_W'(quo);

  // multiplier is shared: release gain first, then the sample scale
  always_comb begin
    if (state_q == ST_RMUL) begin
      mul_a = adsr_pkg::SAMPLE_W'(sus);
      mul_b = dec_gain;
    end else begin
      mul_a = mag_q;
      mul_b = gain_q;
    end
  end

  adsr_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && need_div),
    .num_i   (res_cnt),
    .den_i   (den_d),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  adsr_scale_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= adsr_pkg::ATTACK_RST;
      decay_q   <= adsr_pkg::DECAY_RST;
      release_q <= adsr_pkg::RELEASE_RST;
      sustain_q <= adsr_pkg::SUSTAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adsr_pkg::REG_ATTACK:  attack_q  <= cfg_data_i;
        adsr_pkg::REG_DECAY:   decay_q   <= cfg_data_i;
        adsr_pkg::REG_RELEASE: release_q <= cfg_data_i;
        adsr_pkg::REG_SUSTAIN: sustain_q <= cfg_data_i[adsr_pkg::GAIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= adsr_pkg::PH_IDLE;
      count_q     <= '0;
      mode_q      <= MD_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_OUT the result register is either held or reloaded below
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q          <= nxt_ph;
            count_q          <= nxt_cnt;
            mode_q           <= mode_d;
            mag_q            <= mag_d;
            neg_q            <= in_data_i.sample_in[adsr_pkg::SAMPLE_W-1];
            gain_q           <= (mode_d == MD_SUS) ? sus : '0;
            state_q          <= need_div ? ST_DIV : ST_MUL;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            priority if (mode_q == MD_RELEASE) begin
              state_q <= ST_RMUL;
            end else if (mode_q == MD_DECAY) begin
              gain_q  <= (dec_gain < sus) ? sus : dec_gain;
              state_q <= ST_MUL;
            end else begin
              gain_q  <= adsr_pkg::GAIN_W'(quo);
              state_q <= ST_MUL;
            end
          end
        end
        ST_RMUL: begin
          state_q <= ST_RGAIN;
        end
        ST_RGAIN: begin
          gain_q  <= mul_p[adsr_pkg::GAIN_W-1:0];
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // wait for the output register to free up
          if (!out_valid_q || out_ready_i) begin
            out_q.sample_out <= neg_q ? adsr_pkg::SAMPLE_W'(-mul_p) : mul_p;
            out_q.phase      <= phase_q;
            out_valid_q      <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
